@@ hw/rtl/svpwm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg: shared types and constants for the svpwm duty generator
// Fixed-point formats, projection constant and divider pipeline geometry.
// ----------------------------------------------------------------------------
package svpwm_pkg;

   localparam int FRAC_BITS = 15;
   localparam int ONE       = 1 << FRAC_BITS;

   typedef logic signed [15:0] volt_type;
   typedef logic signed [16:0] time_type;
   typedef logic        [15:0] duty_type;
   typedef logic        [2:0]  sector_type;

   // configuration register indexes
   localparam logic [1:0] CSR_OVERMOD_ENABLE = 2'd0;
   localparam logic [1:0] CSR_OVERMOD_LIMIT  = 2'd1;

   // sector codes: bit0 Va>0, bit1 Vb>0, bit2 Vc>0
   localparam sector_type SECTOR_ZERO = 3'd0;
   localparam sector_type SECTOR_1    = 3'd1;
   localparam sector_type SECTOR_2    = 3'd2;
   localparam sector_type SECTOR_3    = 3'd3;
   localparam sector_type SECTOR_4    = 3'd4;
   localparam sector_type SECTOR_5    = 3'd5;
   localparam sector_type SECTOR_6    = 3'd6;
   localparam sector_type SECTOR_ALL  = 3'd7;

   // sqrt(3) scaled by 2^30
   localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
   localparam int PROD_W = 48;

   // scaling divider: quotient bits, bits per stage, operand widths
   localparam int DIV_QBITS  = 16;
   localparam int DIV_BPS    = 2;
   localparam int DIV_STAGES = DIV_QBITS / DIV_BPS;
   localparam int DIV_NUM_W  = 35;
   localparam int DIV_DEN_W  = 17;

endpackage
`default_nettype wire

@@ hw/rtl/svpwm_div_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_div_pipe: pipelined unsigned restoring divider
// Retires DIV_BPS quotient bits per stage; quotient known to fit DIV_QBITS.
// ----------------------------------------------------------------------------
module svpwm_div_pipe
   import svpwm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic [DIV_NUM_W-1:0] numer,
   input  wire logic [DIV_DEN_W-1:0] denom,
   output logic      [DIV_QBITS-1:0] quot
);

   localparam int EXT_W = DIV_NUM_W + 1;

   logic [DIV_NUM_W-1:0] rem_ff  [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_ff  [DIV_STAGES];
   logic [DIV_QBITS-1:0] quot_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_NUM_W-1:0] rem_src;
      logic [DIV_DEN_W-1:0] den_src;
      logic [DIV_QBITS-1:0] quot_src;
      logic [DIV_NUM_W-1:0] rem_in;
      logic [DIV_QBITS-1:0] quot_in;

      if (k == 0) begin : g_first
         assign rem_src  = numer;
         assign den_src  = denom;
         assign quot_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign quot_src = quot_ff[k-1];
      end

      always_comb begin
         logic [EXT_W-1:0] trial;
         rem_in  = rem_src;
         quot_in = quot_src;
         for (int j = 0; j < DIV_BPS; j++) begin
            trial = EXT_W'(rem_in) - (EXT_W'(den_src) << (DIV_QBITS - 1 - k * DIV_BPS - j));
            if (!trial[EXT_W-1]) begin
               rem_in = trial[DIV_NUM_W-1:0];
            end
            quot_in = {quot_in[DIV_QBITS-2:0], ~trial[EXT_W-1]};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            quot_ff[k] <= quot_in;
         end
      end
   end

   assign quot = quot_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ hw/rtl/svpwm_duty_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_duty_generator: seven-segment space-vector PWM duty generator
// Projects an alpha/beta vector, finds the sector, limits t1+t2 and forms
// saturated centre-aligned phase duties.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | volt_alpha, volt_beta
//  rsp     | out       | rsp_valid / rsp_ready  | sector, t1, t2, three duties
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
//  One transaction per cycle while rsp is not stalled; t1 and t2 are scaled
//  by the eight-stage divider.
//  All stages advance together; a result held at rsp stalls the whole pipe
//  and req_ready drops in the same cycle, so nothing is lost or repeated.
//  Synchronous reset clears valid bits and restores the register defaults.
module svpwm_duty_generator
   import svpwm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire volt_type    req_volt_alpha,
   input  wire volt_type    req_volt_beta,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output sector_type       rsp_sector_code,
   output time_type         rsp_time_first,
   output time_type         rsp_time_second,
   output duty_type         rsp_duty_phase_a,
   output duty_type         rsp_duty_phase_b,
   output duty_type         rsp_duty_phase_c,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int NUM_STAGES = 7 + DIV_STAGES;
   localparam int DIV_FIRST  = 5;
   localparam int F1_STAGE   = DIV_FIRST + DIV_STAGES;
   localparam int SUM_W      = 18;
   localparam int TWICE_W    = 22;
   localparam logic [DIV_DEN_W-1:0] ONE_LIMIT = DIV_DEN_W'(ONE);
   localparam time_type HALF_TIME = 17'(ONE / 2);

   typedef struct packed {
      sector_type code;
      time_type   t1;
      time_type   t2;
      logic       over;
      logic       neg1;
      logic       neg2;
   } meta_type;

   function automatic time_type round_q31(input logic signed [PROD_W:0] n);
      logic [PROD_W:0] mag;
      logic [PROD_W:0] r;
      mag = n[PROD_W] ? (PROD_W+1)'(-n) : (PROD_W+1)'(n);
      r   = (mag + ((PROD_W+1)'(1) << 30)) >> 31;
      return n[PROD_W] ? 17'(-r) : 17'(r);
   endfunction

   function automatic duty_type duty_of(input logic signed [TWICE_W-1:0] twice);
      logic signed [TWICE_W-1:0] r;
      r = (twice + TWICE_W'(1)) >>> 1;
      if (twice <= 0) begin
         return '0;
      end else if (r > TWICE_W'(ONE)) begin
         return 16'(ONE);
      end
      return r[15:0];
   endfunction

   // configuration registers
   logic                 overmod_enable_ff;
   logic [15:0]          overmod_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         overmod_enable_ff <= 1'b0;
         overmod_limit_ff  <= 16'd32768;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OVERMOD_ENABLE: overmod_enable_ff <= csr_data[0];
            CSR_OVERMOD_LIMIT:  overmod_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NUM_STAGES-1:0] vld_ff;
   logic                  pipe_en;

   assign pipe_en   = !vld_ff[NUM_STAGES-1] || rsp_ready;
   assign req_ready = pipe_en;
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   // s1: input register
   volt_type alpha_ff, beta_ff;
   // s2: products
   logic signed [PROD_W-1:0] a3_ff;
   volt_type                 beta2_ff;
   // s3: sector and times
   sector_type code3_ff;
   time_type   t1_3_ff, t2_3_ff;
   // s4: scaling products
   logic [33:0]              p1_ff, p2_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   meta_type                 meta4_ff;
   // s5: divider operands
   logic [DIV_NUM_W-1:0]     n1_ff, n2_ff;
   logic [DIV_DEN_W-1:0]     den_ff;
   meta_type                 meta5_ff;
   meta_type                 meta_dly_ff [DIV_STAGES];
   // f1: scaled times
   time_type                 t1s_ff, t2s_ff;
   meta_type                 meta_f1_ff;

   // s3 logic
   logic signed [PROD_W:0] a3_x, bf_x, ysum, zdif, vbdif;
   time_type               x_t, y_t, z_t;
   sector_type             code_in;
   time_type               t1_in, t2_in;

   always_comb begin
      a3_x  = (PROD_W+1)'(a3_ff);
      bf_x  = (PROD_W+1)'(beta2_ff) <<< 30;
      ysum  = a3_x + bf_x;
      zdif  = bf_x - a3_x;
      vbdif = a3_x - bf_x;
      x_t   = 17'(beta2_ff);
      y_t   = round_q31(ysum);
      z_t   = round_q31(zdif);
      code_in = {ysum < 0, vbdif > 0, beta2_ff > 0};
      unique case (code_in)
         SECTOR_ZERO: begin t1_in = HALF_TIME; t2_in = HALF_TIME; end
         SECTOR_1:    begin t1_in = z_t;  t2_in = y_t;  end
         SECTOR_2:    begin t1_in = y_t;  t2_in = -x_t; end
         SECTOR_3:    begin t1_in = -z_t; t2_in = x_t;  end
         SECTOR_4:    begin t1_in = -x_t; t2_in = z_t;  end
         SECTOR_5:    begin t1_in = x_t;  t2_in = -y_t; end
         SECTOR_6:    begin t1_in = -y_t; t2_in = -z_t; end
         SECTOR_ALL:  begin t1_in = '0;   t2_in = '0;   end
      endcase
   end

   // s4 logic
   logic signed [SUM_W-1:0] sum_in;
   logic [DIV_DEN_W-1:0]    limit;
   logic [16:0]             mag1, mag2;
   meta_type                meta4_in;

   always_comb begin
      sum_in = SUM_W'(t1_3_ff) + SUM_W'(t2_3_ff);
      limit  = overmod_enable_ff ? {1'b0, overmod_limit_ff} : ONE_LIMIT;
      mag1   = t1_3_ff[16] ? 17'(-t1_3_ff) : 17'(t1_3_ff);
      mag2   = t2_3_ff[16] ? 17'(-t2_3_ff) : 17'(t2_3_ff);
      meta4_in.code = code3_ff;
      meta4_in.t1   = t1_3_ff;
      meta4_in.t2   = t2_3_ff;
      meta4_in.over = sum_in > $signed({1'b0, limit});
      meta4_in.neg1 = t1_3_ff[16];
      meta4_in.neg2 = t2_3_ff[16];
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         alpha_ff <= req_volt_alpha;
         beta_ff  <= req_volt_beta;
         a3_ff    <= PROD_W'(alpha_ff) * PROD_W'(SQRT3_Q30);
         beta2_ff <= beta_ff;
         code3_ff <= code_in;
         t1_3_ff  <= t1_in;
         t2_3_ff  <= t2_in;
         p1_ff    <= 34'(mag1) * 34'(limit);
         p2_ff    <= 34'(mag2) * 34'(limit);
         sum_ff   <= sum_in;
         meta4_ff <= meta4_in;
         // round-half-up on the magnitude: add half the divisor
         n1_ff    <= DIV_NUM_W'(p1_ff) + DIV_NUM_W'(sum_ff[SUM_W-1:1]);
         n2_ff    <= DIV_NUM_W'(p2_ff) + DIV_NUM_W'(sum_ff[SUM_W-1:1]);
         den_ff   <= sum_ff[DIV_DEN_W-1:0];
         meta5_ff <= meta4_ff;
         meta_dly_ff[0] <= meta5_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            meta_dly_ff[k] <= meta_dly_ff[k-1];
         end
      end
   end

   logic [DIV_QBITS-1:0] q1, q2;

   svpwm_div_pipe u_div_first (
      .clock  (clock),
      .enable (pipe_en),
      .numer  (n1_ff),
      .denom  (den_ff),
      .quot   (q1)
   );

   svpwm_div_pipe u_div_second (
      .clock  (clock),
      .enable (pipe_en),
      .numer  (n2_ff),
      .denom  (den_ff),
      .quot   (q2)
   );

   // f1 logic: apply sign or bypass when not over the limit
   meta_type meta_div;
   time_type t1s_in, t2s_in;

   always_comb begin
      meta_div = meta_dly_ff[DIV_STAGES-1];
      if (meta_div.over) begin
         t1s_in = meta_div.neg1 ? -17'(q1) : 17'(q1);
         t2s_in = meta_div.neg2 ? -17'(q2) : 17'(q2);
      end else begin
         t1s_in = meta_div.t1;
         t2s_in = meta_div.t2;
      end
   end

   // output stage: doubled on-times, then halve and saturate
   logic signed [TWICE_W-1:0] lo, a2, b2, c2, s1w, s2w, d1w, d2w, d12w;

   always_comb begin
      s1w  = TWICE_W'(t1s_ff);
      s2w  = TWICE_W'(t2s_ff);
      d1w  = s1w <<< 1;
      d2w  = s2w <<< 1;
      d12w = d1w + d2w;
      lo   = TWICE_W'(ONE) - s1w - s2w;
      unique case (meta_f1_ff.code)
         SECTOR_1: begin a2 = lo + d12w; b2 = lo + d2w; c2 = lo; end
         SECTOR_2: begin a2 = lo + d1w; b2 = lo + d12w; c2 = lo; end
         SECTOR_3: begin a2 = lo; b2 = lo + d12w; c2 = lo + d2w; end
         SECTOR_4: begin a2 = lo; b2 = lo + d1w; c2 = lo + d12w; end
         SECTOR_5: begin a2 = lo + d2w; b2 = lo; c2 = lo + d12w; end
         SECTOR_6: begin a2 = lo + d12w; b2 = lo; c2 = lo + d1w; end
         default: begin
            a2 = TWICE_W'(ONE);
            b2 = TWICE_W'(ONE);
            c2 = TWICE_W'(ONE);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t1s_ff           <= t1s_in;
         t2s_ff           <= t2s_in;
         meta_f1_ff       <= meta_div;
         rsp_sector_code  <= meta_f1_ff.code;
         rsp_time_first   <= meta_f1_ff.t1;
         rsp_time_second  <= meta_f1_ff.t2;
         rsp_duty_phase_a <= duty_of(a2);
         rsp_duty_phase_b <= duty_of(b2);
         rsp_duty_phase_c <= duty_of(c2);
      end
   end

   // checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted transaction did not enter the pipe");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipe moved while stalled");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty_phase_a <= 16'(ONE) && rsp_duty_phase_b <= 16'(ONE)
                     && rsp_duty_phase_c <= 16'(ONE)))
      else $error("duty above full scale");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_sector_code == SECTOR_ZERO || rsp_sector_code == SECTOR_ALL))
      |-> (rsp_duty_phase_a == 16'(ONE / 2) && rsp_duty_phase_b == 16'(ONE / 2)
           && rsp_duty_phase_c == 16'(ONE / 2)))
      else $error("zero vector duties not at half");

   a_div_lane_aligned: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[F1_STAGE - 1] && pipe_en) |=> vld_ff[F1_STAGE])
      else $error("divider output lost its valid");

endmodule
`default_nettype wire
